@@ rtl/kmeans_clustering_engine_core_assert.svh @@
// assertion macros for the k-means engine
`ifndef KMEANS_CLUSTERING_ENGINE_CORE_ASSERT_SVH
`define KMEANS_CLUSTERING_ENGINE_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define KMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define KMC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/kmc_pkg.sv @@
// shared constants, types and codes of the k-means engine
package kmc_pkg;

  localparam int MAX_SAMPLES  = 1024;
  localparam int MAX_CLUSTERS = 8;
  localparam int MAX_DIM      = 4;
  localparam int ITER_CAP     = 250;

  localparam int SIDX_W  = $clog2(MAX_SAMPLES);
  localparam int CIDX_W  = $clog2(MAX_CLUSTERS);
  localparam int DIDX_W  = $clog2(MAX_DIM);
  localparam int SADDR_W = SIDX_W + DIDX_W;
  localparam int CADDR_W = CIDX_W + DIDX_W;
  localparam int NCNT_W  = SIDX_W + 1;
  localparam int KCNT_W  = CIDX_W + 1;
  localparam int DCNT_W  = DIDX_W + 1;

  localparam int COORD_W = 16;
  localparam int SUM_W   = 27;
  localparam int SQ_W    = 34;
  localparam int ACC_W   = 36;
  localparam int DSUM_W  = 45;
  localparam int DELTA_W = 22;
  localparam int DIST_W  = 34;
  localparam int TAG_W   = 3;

  localparam int DIV_W   = DSUM_W;
  localparam int DIVR_W  = NCNT_W;
  localparam int DSTEP_W = $clog2(DIV_W + 1);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_CEN  = 2'd2,
    MODE_TAG  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    REG_CLUSTERS  = 2'd0,
    REG_DIMENSION = 2'd1,
    REG_THRESHOLD = 2'd2,
    REG_LIMIT     = 2'd3
  } reg_e;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_TAGRD, ST_DONE,
    ST_INIT_RD, ST_INIT_WR, ST_PASS,
    ST_D_RD, ST_D_SQ, ST_D_AC,
    ST_AS_CMP, ST_AS_TAG, ST_AC_RD, ST_AC_ADD,
    ST_UP_CLU, ST_UP_DIV, ST_UP_WAIT, ST_CHECK,
    ST_DS_TAG, ST_DS_SEL, ST_DS_ACC, ST_DS_DIV, ST_DS_WAIT
  } st_e;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/kmc_if.sv @@
// request and response channel interfaces of the k-means engine
interface kmc_req_if import kmc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  logic signed [15:0]  coordinate;
  logic [SIDX_W-1:0]   item_index;
  logic [DIDX_W-1:0]   dim_index;
  logic [NCNT_W-1:0]   sample_count;

  modport source(output valid, mode, coordinate, item_index, dim_index, sample_count,
                 input ready);
  modport sink(input valid, mode, coordinate, item_index, dim_index, sample_count,
               output ready);
endinterface

interface kmc_rsp_if import kmc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                status;
  logic signed [15:0]  center_value;
  logic [TAG_W-1:0]    tag;
  logic [7:0]          passes;
  logic                converged;
  logic [DIST_W-1:0]   distortion;

  modport source(output valid, status, center_value, tag, passes, converged, distortion,
                 input ready);
  modport sink(input valid, status, center_value, tag, passes, converged, distortion,
               output ready);
endinterface

@@ rtl/kmc_div.sv @@
// restoring divider, one quotient bit per cycle
module kmc_div import kmc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_W-1:0]  dividend_i,
  input  logic [DIVR_W-1:0] divisor_i,
  output div_stat_t         stat_o,
  output logic [DIV_W-1:0]  quotient_o
);

  logic [DIVR_W-1:0]  rem_q, rem_d;
  logic [DIVR_W-1:0]  dvs_q;
  logic [DIV_W-1:0]   quo_q, quo_d;
  logic [DSTEP_W-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [DIVR_W:0]    trial;
  logic               ge;

  // one trial subtract
  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? DIVR_W'(trial - {1'b0, dvs_q}) : trial[DIVR_W-1:0];
    quo_d = {quo_q[DIV_W-2:0], ge};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DSTEP_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

@@ rtl/kmeans_clustering_engine_core.sv @@
// Lloyd k-means engine: samples are loaded one coordinate per beat, and load beats
// can follow back to back. A run is worked by one sequencer around a shared 17x17
// squarer and a shared one-bit-per-cycle divider: each distance term passes a
// read, a square and an accumulate state, every center coordinate of a non-empty
// cluster is averaged on the divider, and the last pass adds the distortion. Center
// reads go straight to the done state, tag reads through a tag-read state first.
// After reset the tag store is cleared, one entry a cycle, all 1024 entries before
// the first beat is taken; configuration writes are taken meanwhile.
module kmeans_clustering_engine_core import kmc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  kmc_req_if.sink             req_i,
  kmc_rsp_if.source           rsp_o
);

  st_e state_q, state_d;

  // configuration
  logic [3:0]  cfg_k_q;
  logic [2:0]  cfg_d_q;
  logic [15:0] cfg_thr_q;
  logic [7:0]  cfg_lim_q;

  // stores
  coord_t           smem [2**SADDR_W];
  logic [TAG_W-1:0] tmem [MAX_SAMPLES];
  coord_t           cen_q  [MAX_CLUSTERS*MAX_DIM];
  logic signed [SUM_W-1:0] sums_q [MAX_CLUSTERS*MAX_DIM];
  logic [NCNT_W-1:0] cnt_q [MAX_CLUSTERS];

  coord_t           smp_q;
  logic [TAG_W-1:0] trd_q;

  // sequencer registers
  logic [NCNT_W-1:0]  i_q, n_q;
  logic [KCNT_W-1:0]  c_q, k_q;
  logic [DCNT_W-1:0]  j_q, d_q;
  logic [SQ_W-1:0]    prod_q;
  logic [ACC_W-1:0]   acc_q, best_q;
  logic [CIDX_W-1:0]  bi_q;
  logic [DSUM_W-1:0]  dsum_q;
  logic [DELTA_W-1:0] delta_q, prev_q;
  logic [7:0]         chk_q, passes_q, lim_q;
  logic               conv_q, ret_q;
  logic [NCNT_W-1:0]  clr_q;

  // result and output registers
  logic              r_status_q, r_conv_q;
  coord_t            r_cen_q;
  logic [TAG_W-1:0]  r_tag_q;
  logic [7:0]        r_passes_q;
  logic [DIST_W-1:0] r_dist_q;
  logic              ovld_q;

  // effective settings
  logic [KCNT_W-1:0] k_eff;
  logic [DCNT_W-1:0] d_eff;
  logic [7:0]        lim_eff;
  logic [NCNT_W-1:0] n_eff;
  logic              acc_in;

  always_comb begin
    if (cfg_k_q == '0) k_eff = KCNT_W'(1);
    else if (cfg_k_q > 4'(MAX_CLUSTERS)) k_eff = KCNT_W'(MAX_CLUSTERS);
    else k_eff = KCNT_W'(cfg_k_q);
    if (cfg_d_q == '0) d_eff = DCNT_W'(1);
    else if (cfg_d_q > 3'(MAX_DIM)) d_eff = DCNT_W'(MAX_DIM);
    else d_eff = DCNT_W'(cfg_d_q);
    lim_eff = (cfg_lim_q > 8'(ITER_CAP)) ? 8'(ITER_CAP) : cfg_lim_q;
    n_eff = (req_i.sample_count > NCNT_W'(MAX_SAMPLES)) ? NCNT_W'(MAX_SAMPLES)
                                                        : req_i.sample_count;
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign acc_in      = req_i.valid && req_i.ready;

  // shared divider
  logic             div_start;
  logic [DIV_W-1:0] div_num, div_quo;
  logic [DIVR_W-1:0] div_den;
  div_stat_t        div_st;

  kmc_div u_div (
    .clk_i, .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .stat_o     (div_st),
    .quotient_o (div_quo)
  );

  // addressing and shared arithmetic
  logic [CADDR_W-1:0]      caddr, saddr_c;
  logic [SADDR_W-1:0]      s_raddr;
  logic [SIDX_W-1:0]       t_raddr;
  logic signed [COORD_W:0] diff;
  logic [COORD_W:0]        dmag;
  logic [2*COORD_W+1:0]    sq_full;
  logic signed [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0]        sum_mag;
  logic                    sum_neg;
  coord_t                  mean_val;
  logic signed [COORD_W:0] mv;
  logic [COORD_W:0]        mv_abs;
  logic [DELTA_W-1:0]      ddiff;
  logic                    win, j_last, c_last, i_last;

  always_comb begin
    caddr   = {c_q[CIDX_W-1:0], j_q[DIDX_W-1:0]};
    saddr_c = {bi_q, j_q[DIDX_W-1:0]};
    j_last  = (j_q + 1'b1) == d_q;
    c_last  = (c_q + 1'b1) == k_q;
    i_last  = (i_q + 1'b1) == n_q;
    win     = (c_q == '0) || (acc_q < best_q);
    diff    = (COORD_W+1)'(smp_q) - (COORD_W+1)'(cen_q[caddr]);
    // square of the magnitude, 17x17 unsigned
    dmag    = diff[COORD_W] ? $unsigned(-diff) : $unsigned(diff);
    sq_full = {{(COORD_W+1){1'b0}}, dmag} * {{(COORD_W+1){1'b0}}, dmag};
    sum_sel = sums_q[caddr];
    sum_neg = sum_sel[SUM_W-1];
    sum_mag = sum_neg ? $unsigned(-sum_sel) : $unsigned(sum_sel);
    mean_val = sum_neg ? -coord_t'(div_quo[COORD_W-1:0]) : coord_t'(div_quo[COORD_W-1:0]);
    mv      = (COORD_W+1)'(cen_q[caddr]) - (COORD_W+1)'(mean_val);
    mv_abs  = mv[COORD_W] ? $unsigned(-mv) : $unsigned(mv);
    ddiff   = (delta_q > prev_q) ? delta_q - prev_q : prev_q - delta_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:   if (clr_q == NCNT_W'(MAX_SAMPLES - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (acc_in) begin
          unique case (mode_e'(req_i.mode))
            MODE_LOAD: state_d = ST_IDLE;
            MODE_CEN:  state_d = ST_DONE;
            MODE_TAG:  state_d = ST_TAGRD;
            MODE_RUN:  state_d = (n_eff < NCNT_W'(k_eff)) ? ST_DONE : ST_INIT_RD;
          endcase
        end
      end
      ST_TAGRD:   state_d = ST_DONE;
      ST_DONE:    if (!ovld_q || rsp_o.ready) state_d = ST_IDLE;
      ST_INIT_RD: state_d = ST_INIT_WR;
      ST_INIT_WR: state_d = (j_last && c_last) ? ST_PASS : ST_INIT_RD;
      ST_PASS:    state_d = ST_D_RD;
      ST_D_RD:    state_d = ST_D_SQ;
      ST_D_SQ:    state_d = ST_D_AC;
      ST_D_AC:    state_d = j_last ? (ret_q ? ST_DS_ACC : ST_AS_CMP) : ST_D_RD;
      ST_AS_CMP:  state_d = c_last ? ST_AS_TAG : ST_D_RD;
      ST_AS_TAG:  state_d = ST_AC_RD;
      ST_AC_RD:   state_d = ST_AC_ADD;
      ST_AC_ADD:  state_d = j_last ? (i_last ? ST_UP_CLU : ST_D_RD) : ST_AC_RD;
      ST_UP_CLU: begin
        if (c_q == k_q) state_d = ST_CHECK;
        else if (cnt_q[c_q[CIDX_W-1:0]] != '0) state_d = ST_UP_DIV;
      end
      ST_UP_DIV:  state_d = ST_UP_WAIT;
      ST_UP_WAIT: if (div_st.done) state_d = j_last ? ST_UP_CLU : ST_UP_DIV;
      ST_CHECK: begin
        if (ddiff < DELTA_W'(cfg_thr_q) || chk_q > lim_q) state_d = ST_DS_TAG;
        else state_d = ST_PASS;
      end
      ST_DS_TAG:  state_d = ST_DS_SEL;
      ST_DS_SEL:  state_d = ST_D_RD;
      ST_DS_ACC:  state_d = i_last ? ST_DS_DIV : ST_DS_TAG;
      ST_DS_DIV:  state_d = ST_DS_WAIT;
      ST_DS_WAIT: if (div_st.done) state_d = ST_DONE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // memory ports and divider operands
  always_comb begin
    s_raddr   = {i_q[SIDX_W-1:0], j_q[DIDX_W-1:0]};
    t_raddr   = i_q[SIDX_W-1:0];
    div_start = 1'b0;
    div_num   = DIV_W'(sum_mag);
    div_den   = cnt_q[c_q[CIDX_W-1:0]];
    unique case (state_q)
      ST_IDLE:    t_raddr = req_i.item_index;
      ST_INIT_RD: s_raddr = {SIDX_W'(c_q), j_q[DIDX_W-1:0]};
      ST_UP_DIV:  div_start = 1'b1;
      ST_DS_DIV: begin
        div_start = 1'b1;
        div_num   = DIV_W'(dsum_q);
        div_den   = n_q;
      end
      default: ;
    endcase
  end

  // sample and tag memories
  always_ff @(posedge clk_i) begin
    if (acc_in && mode_e'(req_i.mode) == MODE_LOAD)
      smem[{req_i.item_index, req_i.dim_index}] <= req_i.coordinate;
    smp_q <= smem[s_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) tmem[clr_q[SIDX_W-1:0]] <= '0;
    else if (state_q == ST_AS_TAG) tmem[i_q[SIDX_W-1:0]] <= bi_q;
    trd_q <= tmem[t_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      ovld_q    <= 1'b0;
      cfg_k_q   <= 4'd2;
      cfg_d_q   <= 3'd2;
      cfg_thr_q <= 16'd8;
      cfg_lim_q <= 8'd100;
      for (int e = 0; e < MAX_CLUSTERS*MAX_DIM; e++) cen_q[e] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (cfg_we_i) begin
        unique case (reg_e'(cfg_idx_i))
          REG_CLUSTERS:  cfg_k_q   <= cfg_wdata_i[3:0];
          REG_DIMENSION: cfg_d_q   <= cfg_wdata_i[2:0];
          REG_THRESHOLD: cfg_thr_q <= cfg_wdata_i;
          REG_LIMIT:     cfg_lim_q <= cfg_wdata_i[7:0];
        endcase
      end
      if (rsp_o.ready) ovld_q <= 1'b0;
      if (state_q == ST_DONE && (!ovld_q || rsp_o.ready)) ovld_q <= 1'b1;
      // center writes: initial pick and mean update
      if (state_q == ST_INIT_WR) cen_q[caddr] <= smp_q;
      if (state_q == ST_UP_WAIT && div_st.done) cen_q[caddr] <= mean_val;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (acc_in) begin
          r_status_q <= 1'b0;
          r_cen_q    <= '0;
          r_tag_q    <= '0;
          r_passes_q <= '0;
          r_conv_q   <= 1'b0;
          r_dist_q   <= '0;
          k_q      <= k_eff;
          d_q      <= d_eff;
          n_q      <= n_eff;
          lim_q    <= lim_eff;
          c_q      <= '0;
          j_q      <= '0;
          delta_q  <= '0;
          prev_q   <= '0;
          chk_q    <= '0;
          passes_q <= '0;
          conv_q   <= 1'b0;
          if (mode_e'(req_i.mode) == MODE_CEN && req_i.item_index < SIDX_W'(MAX_CLUSTERS))
            r_cen_q <= cen_q[{req_i.item_index[CIDX_W-1:0], req_i.dim_index}];
          if (mode_e'(req_i.mode) == MODE_RUN && n_eff < NCNT_W'(k_eff))
            r_status_q <= 1'b1;
        end
      end
      ST_TAGRD: r_tag_q <= trd_q;
      ST_INIT_WR: begin
        if (j_last) begin
          j_q <= '0;
          c_q <= c_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
      ST_PASS: begin
        for (int e = 0; e < MAX_CLUSTERS*MAX_DIM; e++) sums_q[e] <= '0;
        for (int e = 0; e < MAX_CLUSTERS; e++) cnt_q[e] <= '0;
        prev_q  <= delta_q;
        delta_q <= '0;
        i_q     <= '0;
        c_q     <= '0;
        j_q     <= '0;
        acc_q   <= '0;
        ret_q   <= 1'b0;
      end
      ST_D_SQ: prod_q <= sq_full[SQ_W-1:0];
      ST_D_AC: begin
        acc_q <= acc_q + ACC_W'(prod_q);
        j_q   <= j_last ? '0 : j_q + 1'b1;
      end
      ST_AS_CMP: begin
        if (win) begin
          best_q <= acc_q;
          bi_q   <= c_q[CIDX_W-1:0];
        end
        if (win && c_last) bi_q <= c_q[CIDX_W-1:0];
        acc_q <= '0;
        if (!c_last) c_q <= c_q + 1'b1;
      end
      ST_AS_TAG: begin
        cnt_q[bi_q] <= cnt_q[bi_q] + 1'b1;
        j_q <= '0;
      end
      ST_AC_ADD: begin
        sums_q[saddr_c] <= sums_q[saddr_c] + SUM_W'(smp_q);
        if (j_last) begin
          j_q   <= '0;
          c_q   <= '0;
          acc_q <= '0;
          i_q   <= i_q + 1'b1;
          if (i_last) c_q <= '0;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
      ST_UP_CLU: begin
        j_q <= '0;
        if (c_q != k_q && cnt_q[c_q[CIDX_W-1:0]] == '0) c_q <= c_q + 1'b1;
      end
      ST_UP_WAIT: begin
        if (div_st.done) begin
          delta_q <= delta_q + DELTA_W'(mv_abs);
          if (j_last) begin
            j_q <= '0;
            c_q <= c_q + 1'b1;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
      end
      ST_CHECK: begin
        passes_q <= passes_q + 1'b1;
        if (ddiff < DELTA_W'(cfg_thr_q)) conv_q <= 1'b1;
        else chk_q <= chk_q + 1'b1;
        i_q    <= '0;
        dsum_q <= '0;
      end
      ST_DS_SEL: begin
        c_q   <= KCNT_W'(trd_q);
        j_q   <= '0;
        acc_q <= '0;
        ret_q <= 1'b1;
      end
      ST_DS_ACC: begin
        dsum_q <= dsum_q + DSUM_W'(acc_q);
        i_q    <= i_q + 1'b1;
      end
      ST_DS_WAIT: begin
        if (div_st.done) begin
          r_dist_q   <= div_quo[DIST_W-1:0];
          r_passes_q <= passes_q;
          r_conv_q   <= conv_q;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && (!ovld_q || rsp_o.ready)) begin
      rsp_o.status       <= r_status_q;
      rsp_o.center_value <= r_cen_q;
      rsp_o.tag          <= r_tag_q;
      rsp_o.passes       <= r_passes_q;
      rsp_o.converged    <= r_conv_q;
      rsp_o.distortion   <= r_dist_q;
    end
  end

  assign rsp_o.valid = ovld_q;

`include "kmeans_clustering_engine_core_assert.svh"

  `KMC_ASSERT(a_div_idle_start, div_start |-> !div_st.busy, "divider restarted while busy")
  `KMC_ASSERT(a_rsp_from_done, $rose(ovld_q) |-> $past(state_q == ST_DONE), "beat not from done")
  `KMC_ASSERT(a_tag_range, state_q == ST_AS_TAG |-> KCNT_W'(bi_q) < k_q, "tag beyond cluster count")
  `KMC_ASSERT_NEXT(a_div_wait, state_q == ST_UP_DIV, div_st.busy, "divider not started")

endmodule
